// ===== rtl/acgpe_pkg.sv =====
// Shared constants and codes for the adjacent-change Gray path enumerator.
package acgpe_pkg;

    // Longest path the stores can hold (two to the largest bit count).
    localparam int PATH_LENGTH = 64;
    localparam int ADDR_W      = $clog2(PATH_LENGTH);
    localparam int DEPTH_W     = ADDR_W + 1;
    localparam int TRIED_W     = 2;
    localparam int STK_W       = TRIED_W + ADDR_W;

    // Fixed field widths of the item ports.
    localparam int VX_W    = 6;
    localparam int COUNT_W = 32;
    localparam int BITS_W  = 3;

    localparam logic [BITS_W-1:0]  BITS_MIN    = 3'd3;
    localparam logic [BITS_W-1:0]  BITS_MAX    = BITS_W'(ADDR_W);
    localparam logic [BITS_W-1:0]  BITS_RESET  = 3'd6;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 32'd1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATH_LIMIT = 1'd1;

    // Branch progress kept per search level.
    localparam logic [TRIED_W-1:0] TRIED_NONE  = 2'd0;
    localparam logic [TRIED_W-1:0] TRIED_RIGHT = 2'd1;
    localparam logic [TRIED_W-1:0] TRIED_BOTH  = 2'd2;

endpackage

// ===== rtl/ac_gray_path_enumerator.sv =====
// Timing is data dependent: a branch with no candidate ends in S_SRCH, a move adds S_CHK, a
// backtrack S_POP, S_POP_RD1/2 (or S_OUTER to S_CHECK_LIM at a new first flip), a result
// S_OUT_RD, S_OUT_LD, S_WAIT (held by an output stall). A restart (or first) request first
// sweeps the stores. One request at a time; the single sequencer and its two RAM ports set
// the pace. Reset (synchronous, active low) clears the sequencer, search phase, settings,
// depth and count; the stores are swept at the start of the first search, not at reset.
module ac_gray_path_enumerator
    import acgpe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_restart,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [VX_W-1:0]      o_vertex,
    output logic [VX_W-1:0]      o_change_word,
    output logic [VX_W-1:0]      o_position,
    output logic [COUNT_W-1:0]   o_path_number,
    output logic                 o_done_res,
    output logic                 o_last,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COUNT_W-1:0]   i_cfg_data
);

    // The sequencer walks the depth-first search one decision at a time. The
    // stack RAM holds, per level, the vertex and how many of its two branches
    // (right neighbour, then left neighbour) have been tried; the visited RAM
    // marks vertices on the current path. The top of the stack and the vertex
    // below it are cached in registers so that a forward step needs no stack read.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_PLACE_A,
        S_PLACE_B,
        S_CHECK_LIM,
        S_SRCH,
        S_CHK,
        S_POP,
        S_POP_RD1,
        S_POP_RD2,
        S_OUTER,
        S_OUT_RD,
        S_OUT_LD,
        S_DONE_LD,
        S_WAIT
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RUN,
        PH_DONE
    } t_phase;

    t_state              r_state;
    t_phase              r_phase;
    logic [BITS_W-1:0]   r_bit_count;
    logic [COUNT_W-1:0]  r_limit;
    logic [BITS_W-1:0]   r_cur_bits;
    logic [DEPTH_W-1:0]  r_depth;
    logic [COUNT_W-1:0]  r_count;
    logic [ADDR_W-1:0]   r_top_v;
    logic [TRIED_W-1:0]  r_top_tried;
    logic [ADDR_W-1:0]   r_prev_v;
    logic [ADDR_W-1:0]   r_f;
    logic [ADDR_W-1:0]   r_w;
    logic [ADDR_W-1:0]   r_clr;
    logic [ADDR_W-1:0]   r_j;
    logic [ADDR_W-1:0]   r_last_vx;

    logic                r_o_valid;
    logic [VX_W-1:0]     r_o_vertex;
    logic [VX_W-1:0]     r_o_change;
    logic [VX_W-1:0]     r_o_position;
    logic [COUNT_W-1:0]  r_o_number;
    logic                r_o_done;
    logic                r_o_last;

    // Store ports
    logic                stk_we;
    logic [ADDR_W-1:0]   stk_waddr;
    logic [STK_W-1:0]    stk_wdata;
    logic [ADDR_W-1:0]   stk_raddr;
    logic [STK_W-1:0]    stk_rdata;
    logic                vis_we;
    logic [ADDR_W-1:0]   vis_waddr;
    logic [0:0]          vis_wdata;
    logic [ADDR_W-1:0]   vis_raddr;
    logic [0:0]          vis_rdata;

    // Search arithmetic shared by every step
    logic [BITS_W-1:0]   eff_bits;
    logic [DEPTH_W-1:0]  len;
    logic [ADDR_W-1:0]   mask;
    logic [DEPTH_W-1:0]  nh;
    logic [ADDR_W-1:0]   v1;
    logic [ADDR_W-1:0]   v2;
    logic [ADDR_W-1:0]   b;
    logic [TRIED_W-1:0]  tried_inc;
    logic [ADDR_W-1:0]   c;
    logic [ADDR_W-1:0]   w;
    logic                in_range;
    logic [DEPTH_W-1:0]  next_f;
    logic [ADDR_W-1:0]   out_vx;

    acgpe_ram #(.WIDTH(STK_W), .DEPTH(PATH_LENGTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    acgpe_ram #(.WIDTH(1), .DEPTH(PATH_LENGTH)) u_visited (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_raddr (vis_raddr),
        .o_rdata (vis_rdata)
    );

    // The written bit count is saturated into the supported range when a
    // search starts; changing it mid-search has no effect until then.
    always_comb begin
        eff_bits = r_bit_count;
        if (eff_bits > BITS_MAX) begin
            eff_bits = BITS_MAX;
        end
        if (eff_bits < BITS_MIN) begin
            eff_bits = BITS_MIN;
        end
    end

    assign len  = DEPTH_W'(1) << r_cur_bits;
    assign mask = ADDR_W'(len - DEPTH_W'(1));
    // Outer loop bound: the first flip stays below 2^(n/2)+1.
    assign nh   = (DEPTH_W'(1) << (r_cur_bits >> 1)) + DEPTH_W'(1);

    // First two vertices for a given first flip; the second flip doubles it.
    assign v1 = r_f & mask;
    assign v2 = (v1 ^ (r_f << 1)) & mask;

    // Next branch at the top of the stack: right neighbour first, then left.
    assign b         = (r_top_v ^ r_prev_v) & mask;
    assign tried_inc = r_top_tried + TRIED_W'(1);
    assign c         = (tried_inc == TRIED_RIGHT) ? ((b >> 1) & mask) : ((b << 1) & mask);
    assign w         = (r_top_v ^ c) & mask;
    assign in_range  = (r_depth >= DEPTH_W'(3)) && (r_depth <= len);

    assign next_f = DEPTH_W'(r_prev_v) << 1;
    assign out_vx = stk_rdata[ADDR_W-1:0];

    // Store port steering by sequencer state
    always_comb begin
        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = '0;
        stk_raddr = '0;
        vis_we    = 1'b0;
        vis_waddr = '0;
        vis_wdata = '0;
        vis_raddr = '0;
        case (r_state)
            S_CLEAR: begin
                stk_we    = 1'b1;
                stk_waddr = r_clr;
                stk_wdata = '0;
                vis_we    = 1'b1;
                vis_waddr = r_clr;
                vis_wdata = (r_clr == '0);
            end
            S_PLACE_A: begin
                stk_we    = 1'b1;
                stk_waddr = ADDR_W'(1);
                stk_wdata = {TRIED_NONE, v1};
                vis_we    = 1'b1;
                vis_waddr = v1;
                vis_wdata = 1'b1;
            end
            S_PLACE_B: begin
                stk_we    = 1'b1;
                stk_waddr = ADDR_W'(2);
                stk_wdata = {TRIED_NONE, v2};
                vis_we    = 1'b1;
                vis_waddr = v2;
                vis_wdata = 1'b1;
            end
            S_SRCH: begin
                if (in_range && (r_top_tried != TRIED_BOTH)) begin
                    stk_we    = 1'b1;
                    stk_waddr = ADDR_W'(r_depth - DEPTH_W'(1));
                    stk_wdata = {tried_inc, r_top_v};
                end
                vis_raddr = w;
            end
            S_CHK: begin
                if (vis_rdata == 1'b0) begin
                    stk_we    = 1'b1;
                    stk_waddr = r_depth[ADDR_W-1:0];
                    stk_wdata = {TRIED_NONE, r_w};
                    vis_we    = 1'b1;
                    vis_waddr = r_w;
                    vis_wdata = 1'b1;
                end
            end
            S_POP: begin
                vis_we    = 1'b1;
                vis_waddr = r_top_v;
                vis_wdata = 1'b0;
                stk_raddr = ADDR_W'(r_depth - DEPTH_W'(2));
            end
            S_POP_RD1: begin
                stk_raddr = ADDR_W'(r_depth - DEPTH_W'(2));
            end
            S_OUTER: begin
                vis_we    = 1'b1;
                vis_waddr = r_prev_v;
                vis_wdata = 1'b0;
            end
            S_OUT_RD: begin
                stk_raddr = r_j;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_bit_count <= BITS_RESET;
            r_limit     <= LIMIT_RESET;
            r_cur_bits  <= BITS_RESET;
            r_depth     <= '0;
            r_count     <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BIT_COUNT:  r_bit_count <= i_cfg_data[BITS_W-1:0];
                    CFG_PATH_LIMIT: r_limit     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_restart || (r_phase == PH_IDLE)) begin
                            r_cur_bits <= eff_bits;
                            r_count    <= '0;
                            r_phase    <= PH_RUN;
                            r_clr      <= '0;
                            r_state    <= S_CLEAR;
                        end else begin
                            r_state <= S_CHECK_LIM;
                        end
                    end
                end
                S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == ADDR_W'(PATH_LENGTH - 1)) begin
                        r_f     <= ADDR_W'(1);
                        r_state <= S_PLACE_A;
                    end
                end
                S_PLACE_A: begin
                    r_state <= S_PLACE_B;
                end
                S_PLACE_B: begin
                    r_top_v     <= v2;
                    r_top_tried <= TRIED_NONE;
                    r_prev_v    <= v1;
                    r_depth     <= DEPTH_W'(3);
                    r_state     <= S_CHECK_LIM;
                end
                S_CHECK_LIM: begin
                    // The count cannot move within a request, so passing
                    // through here again after a new first flip is harmless.
                    if ((r_phase != PH_RUN) ||
                        ((r_limit != '0) && (r_count >= r_limit))) begin
                        r_state <= S_DONE_LD;
                    end else begin
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (!in_range) begin
                        r_state <= S_DONE_LD;
                    end else if (r_top_tried != TRIED_BOTH) begin
                        r_top_tried <= tried_inc;
                        r_w         <= w;
                        if ((c != '0) && (r_depth < len)) begin
                            r_state <= S_CHK;
                        end
                    end else begin
                        r_state <= S_POP;
                    end
                end
                S_CHK: begin
                    if (vis_rdata == 1'b0) begin
                        r_prev_v    <= r_top_v;
                        r_top_v     <= r_w;
                        r_top_tried <= TRIED_NONE;
                        r_depth     <= r_depth + DEPTH_W'(1);
                        if ((r_depth + DEPTH_W'(1)) == len) begin
                            r_count <= r_count + COUNT_W'(1);
                            r_j     <= '0;
                            r_state <= S_OUT_RD;
                        end else begin
                            r_state <= S_SRCH;
                        end
                    end else begin
                        r_state <= S_SRCH;
                    end
                end
                S_POP: begin
                    r_depth <= r_depth - DEPTH_W'(1);
                    if ((r_depth - DEPTH_W'(1)) == DEPTH_W'(2)) begin
                        r_state <= S_OUTER;
                    end else begin
                        r_top_v <= r_prev_v;
                        r_state <= S_POP_RD1;
                    end
                end
                S_POP_RD1: begin
                    r_top_tried <= stk_rdata[STK_W-1:ADDR_W];
                    r_state     <= S_POP_RD2;
                end
                S_POP_RD2: begin
                    r_prev_v <= out_vx;
                    r_state  <= S_SRCH;
                end
                S_OUTER: begin
                    if (next_f >= nh) begin
                        r_state <= S_DONE_LD;
                    end else begin
                        r_f     <= ADDR_W'(next_f);
                        r_state <= S_PLACE_A;
                    end
                end
                S_OUT_RD: begin
                    r_state <= S_OUT_LD;
                end
                S_OUT_LD: begin
                    r_o_valid    <= 1'b1;
                    r_o_vertex   <= VX_W'(out_vx);
                    r_o_change   <= (r_j == '0) ? '0 : VX_W'(out_vx ^ r_last_vx);
                    r_o_position <= VX_W'(r_j);
                    r_o_number   <= r_count;
                    r_o_done     <= 1'b0;
                    r_o_last     <= (r_j == mask);
                    r_last_vx    <= out_vx;
                    r_state      <= S_WAIT;
                end
                S_DONE_LD: begin
                    r_phase      <= PH_DONE;
                    r_o_valid    <= 1'b1;
                    r_o_vertex   <= '0;
                    r_o_change   <= '0;
                    r_o_position <= '0;
                    r_o_number   <= r_count;
                    r_o_done     <= 1'b1;
                    r_o_last     <= 1'b1;
                    r_state      <= S_WAIT;
                end
                S_WAIT: begin
                    if (!i_stall) begin
                        r_o_valid <= 1'b0;
                        if (r_o_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + ADDR_W'(1);
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_o_valid;
    assign o_vertex      = r_o_vertex;
    assign o_change_word = r_o_change;
    assign o_position    = r_o_position;
    assign o_path_number = r_o_number;
    assign o_done_res    = r_o_done;
    assign o_last        = r_o_last;

`ifndef SYNTHESIS
    // A search step only ever runs on a stack of at least three levels.
    a_srch_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> ((r_depth >= DEPTH_W'(3)) && (r_depth <= len)))
        else $error("search step on an out-of-range stack depth");

    // A move is only checked while the path is still short of full length.
    a_chk_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (r_depth < len))
        else $error("move checked on a full path");

    // No request is taken while a result is still on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !o_valid)
        else $error("request channel open while a result is pending");

    // A done result leaves the search finished and the block free.
    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> (r_phase == PH_DONE))
        else $error("done result while the search is still running");

    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last) |=> (r_state == S_IDLE))
        else $error("block busy after the final result of a request");
`endif

endmodule

// ===== rtl/acgpe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module acgpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
